>>> src/mnas_pkg.sv
// ----------------------------------------------------------------------------
// mnas_pkg: shared types and constants of the mail name/address splitter
// Character codes, parser modes, result roles and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mnas_pkg;

  localparam int unsigned BlankCountBitsDefault = 8;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLt        = 8'h3C;
  localparam logic [7:0] ChGt        = 8'h3E;
  localparam logic [7:0] ChBlank     = 8'h20;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [2:0] {
    ModeLead       = 3'd0,
    ModeUnquoted   = 3'd1,
    ModeQuoted     = 3'd2,
    ModeEscape     = 3'd3,
    ModeAfterQuote = 3'd4,
    ModeAngle      = 3'd5,
    ModePost       = 3'd6,
    ModeGarbage    = 3'd7
  } parse_mode_e;

  typedef enum logic [1:0] {
    RoleName    = 2'd0,
    RoleAddress = 2'd1,
    RoleText    = 2'd2,
    RoleEnd     = 2'd3
  } role_e;

  typedef struct packed {
    logic       valid;
    role_e      role;
    logic [7:0] out_char;
    logic [7:0] blanks_before;
    logic       text_is_address;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

>>> src/mnas_parser.sv
// ----------------------------------------------------------------------------
// mnas_parser: parse state machine, one request per step
// Holds the parse mode and the held blank count and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mnas_parser #(
  parameter int unsigned BLANK_COUNT_BITS = mnas_pkg::BlankCountBitsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            kind_i,
  input  wire logic [7:0]      char_code_i,
  input  wire logic            report_errors_i,
  output mnas_pkg::result_t    result_o
);

  mnas_pkg::parse_mode_e mode_q, mode_d;
  logic [BLANK_COUNT_BITS-1:0] held_q, held_d;
  logic [7:0] held_sat;

  logic is_blank, is_quote, is_lt, is_gt, is_bslash;
  assign is_blank  = (char_code_i == mnas_pkg::ChBlank);
  assign is_quote  = (char_code_i == mnas_pkg::ChQuote);
  assign is_lt     = (char_code_i == mnas_pkg::ChLt);
  assign is_gt     = (char_code_i == mnas_pkg::ChGt);
  assign is_bslash = (char_code_i == mnas_pkg::ChBackslash);

  // held count shown on the 8-bit port, saturating
  if (BLANK_COUNT_BITS > 8) begin : g_sat_wide
    assign held_sat = (held_q > BLANK_COUNT_BITS'(255)) ? 8'hFF : held_q[7:0];
  end else if (BLANK_COUNT_BITS == 8) begin : g_sat_same
    assign held_sat = held_q;
  end else begin : g_sat_narrow
    assign held_sat = {{(8 - BLANK_COUNT_BITS){1'b0}}, held_q};
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    if (kind_i == mnas_pkg::KindEnd) begin
      mode_d = mnas_pkg::ModeLead;
      held_d = '0;
    end else begin
      unique case (mode_q)
        mnas_pkg::ModeLead: begin
          if (is_quote) begin
            mode_d = mnas_pkg::ModeQuoted;
          end else if (is_lt) begin
            mode_d = mnas_pkg::ModeAngle;
          end else if (!is_blank) begin
            mode_d = mnas_pkg::ModeUnquoted;
            held_d = '0;
          end
        end
        mnas_pkg::ModeUnquoted: begin
          if (is_blank) begin
            if (held_q != '1) begin
              held_d = held_q + BLANK_COUNT_BITS'(1);
            end
          end else begin
            held_d = '0;
            if (is_lt) begin
              mode_d = mnas_pkg::ModeAngle;
            end
          end
        end
        mnas_pkg::ModeQuoted: begin
          if (is_quote) begin
            mode_d = mnas_pkg::ModeAfterQuote;
          end else if (is_bslash) begin
            mode_d = mnas_pkg::ModeEscape;
          end
        end
        mnas_pkg::ModeEscape: begin
          mode_d = mnas_pkg::ModeQuoted;
        end
        mnas_pkg::ModeAfterQuote: begin
          if (!is_blank) begin
            mode_d = is_lt ? mnas_pkg::ModeAngle : mnas_pkg::ModeGarbage;
          end
        end
        mnas_pkg::ModeAngle: begin
          if (is_gt) begin
            mode_d = mnas_pkg::ModePost;
          end
        end
        mnas_pkg::ModePost: begin
          if (!is_blank) begin
            mode_d = mnas_pkg::ModeGarbage;
          end
        end
        mnas_pkg::ModeGarbage: begin
          mode_d = mode_q;
        end
        default: begin
          mode_d = mnas_pkg::ModeLead;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    result_o                 = '0;
    result_o.role            = mnas_pkg::RoleName;
    result_o.out_char        = char_code_i;
    if (kind_i == mnas_pkg::KindEnd) begin
      result_o.valid           = 1'b1;
      result_o.role            = mnas_pkg::RoleEnd;
      result_o.out_char        = '0;
      result_o.text_is_address = (mode_q == mnas_pkg::ModeLead) ||
                                 (mode_q == mnas_pkg::ModeUnquoted);
      result_o.status          = (mode_q == mnas_pkg::ModeGarbage) && report_errors_i;
    end else begin
      unique case (mode_q)
        mnas_pkg::ModeLead: begin
          result_o.valid = !(is_blank || is_quote || is_lt);
          result_o.role  = mnas_pkg::RoleText;
        end
        mnas_pkg::ModeUnquoted: begin
          result_o.valid         = !(is_blank || is_lt);
          result_o.role          = mnas_pkg::RoleText;
          result_o.blanks_before = held_sat;
        end
        mnas_pkg::ModeQuoted: begin
          result_o.valid = !(is_quote || is_bslash);
          result_o.role  = mnas_pkg::RoleName;
        end
        mnas_pkg::ModeEscape: begin
          result_o.valid = 1'b1;
          result_o.role  = mnas_pkg::RoleName;
        end
        mnas_pkg::ModeAngle: begin
          result_o.valid = !is_gt;
          result_o.role  = mnas_pkg::RoleAddress;
        end
        mnas_pkg::ModeAfterQuote, mnas_pkg::ModePost, mnas_pkg::ModeGarbage: begin
          result_o.valid = 1'b0;
        end
        default: begin
          result_o.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mnas_pkg::ModeLead;
      held_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mail_name_address_splitter_unit.sv
// ----------------------------------------------------------------------------
// mail_name_address_splitter_unit: mail header name/address splitter
// Splits header text, one byte per request, into name and address bytes.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                                   tuser
//  s_axis    in         [7:0] char_code                         kind
//  m_axis    out        [7:0] out_char [15:8] blanks_before     role
//                       [16] text_is_address [17] status
//  cfg       in         cfg_wdata_i = report_errors, written on cfg_we_i
//
//  one request per cycle sustained while the result register is not stalled;
//  a request goes from the input register to the result register through the single parser step between them
//  reset clears the parse state and sets report_errors to 1
//  a stalled result register holds the input register, which in turn
//  drops s_axis_tready; requests that give no result still pass through
// ----------------------------------------------------------------------------
`default_nettype none

module mail_name_address_splitter_unit #(
  parameter int unsigned BLANK_COUNT_BITS = mnas_pkg::BlankCountBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tuser,   // [0] kind
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [7:0] out_char, [15:8] blanks_before,
                                           // [16] text_is_address, [17] status
  output      logic [1:0]  m_axis_tuser,   // [1:0] role
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i
);

  logic       in_valid_q;
  logic       in_kind_q;
  logic [7:0] in_char_q;
  logic       report_q;
  logic       advance;
  logic       out_valid_q, out_valid_d;
  mnas_pkg::result_t res, out_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q <= 1'b1;
    end else if (cfg_we_i) begin
      report_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
  end

  mnas_parser #(
    .BLANK_COUNT_BITS(BLANK_COUNT_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .kind_i          (in_kind_q),
    .char_code_i     (in_char_q),
    .report_errors_i (report_q),
    .result_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.role;
  assign m_axis_tdata  = {6'b0, out_q.status, out_q.text_is_address,
                          out_q.blanks_before, out_q.out_char};

`ifndef NO_ASSERTIONS
  // end-of-text results carry no byte and no blank count
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == mnas_pkg::RoleEnd)) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("end result carries byte data");

  // byte results never carry end flags
  a_byte_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != mnas_pkg::RoleEnd)) |-> (m_axis_tdata[17:16] == 2'd0))
    else $error("byte result carries end flags");

  // only unquoted text bytes may carry held blanks
  a_blanks_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != mnas_pkg::RoleText)) |-> (m_axis_tdata[15:8] == 8'd0))
    else $error("blanks on a non-text result");

  // an accepted request is held in the input register next cycle
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted request lost");
`endif

endmodule

`default_nettype wire
